// File: src/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the source text tokenizer.
// Depends on nothing; every other file imports it.
package stt_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;

  localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = {COLUMN_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  localparam int KW_COUNT = 13;
  localparam int MAX_RES  = 3;

  localparam logic [5:0] KIND_IDENT    = 6'd0;
  localparam logic [5:0] KIND_NUMBER   = 6'd14;
  localparam logic [5:0] KIND_STRING   = 6'd15;
  localparam logic [5:0] KIND_SINGLE0  = 6'd16;
  localparam logic [5:0] KIND_ASSIGN   = 6'd29;
  localparam logic [5:0] KIND_EQ       = 6'd30;
  localparam logic [5:0] KIND_NE       = 6'd31;
  localparam logic [5:0] KIND_LT       = 6'd32;
  localparam logic [5:0] KIND_LE       = 6'd33;
  localparam logic [5:0] KIND_GT       = 6'd34;
  localparam logic [5:0] KIND_GE       = 6'd35;
  localparam logic [5:0] KIND_UNKNOWN  = 6'd36;
  localparam logic [5:0] KIND_END      = 6'd37;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Keyword text, right aligned: the first byte is the most significant one in use.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("if"), 64'("else"), 64'("for"), 64'("while"), 64'("do"), 64'("fn"),
    64'("int"), 64'("char"), 64'("double"), 64'("string"), 64'("return"),
    64'("break"), 64'("continue")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd2, 4'd3, 4'd4, 4'd6, 4'd6, 4'd6, 4'd5, 4'd8
  };
  localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};

  typedef struct packed {
    logic [5:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] text_length;
    logic [7:0]             symbol_byte;
  } stt_res_t;

  typedef struct packed {
    stt_res_t [MAX_RES-1:0] res;
    logic [1:0]             count;
  } stt_pkt_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_adv(input logic [LINE_BITS-1:0] l,
                                                    input logic [7:0] c);
    return (c == CH_LF && l != LINE_MAX) ? l + 1'b1 : l;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_adv(input logic [COLUMN_BITS-1:0] col,
                                                     input logic [7:0] c);
    logic [COLUMN_BITS-1:0] r;
    if (c == CH_LF) r = COLUMN_BITS'(1);
    else if (col != COLUMN_MAX) r = col + 1'b1;
    else r = col;
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] n);
    return (n != LENGTH_MAX) ? n + 1'b1 : n;
  endfunction

  // Drops every keyword that is no longer than pos or whose byte at position pos is not c.
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] mask,
                                                    input logic [LENGTH_BITS-1:0] pos,
                                                    input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    logic [2:0]          bi;
    m = mask;
    for (int k = 0; k < KW_COUNT; k++) begin
      bi = 3'(KW_LEN[k] - 4'd1) - pos[2:0];
      if (pos >= LENGTH_BITS'(KW_LEN[k]) || KW_TEXT[k][{bi, 3'b000} +: 8] != c) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h2B:   r = KIND_SINGLE0;
      8'h2D:   r = KIND_SINGLE0 + 6'd1;
      8'h2A:   r = KIND_SINGLE0 + 6'd2;
      8'h2F:   r = KIND_SINGLE0 + 6'd3;
      8'h25:   r = KIND_SINGLE0 + 6'd4;
      8'h28:   r = KIND_SINGLE0 + 6'd5;
      8'h29:   r = KIND_SINGLE0 + 6'd6;
      8'h7B:   r = KIND_SINGLE0 + 6'd7;
      8'h7D:   r = KIND_SINGLE0 + 6'd8;
      8'h5B:   r = KIND_SINGLE0 + 6'd9;
      8'h5D:   r = KIND_SINGLE0 + 6'd10;
      8'h2C:   r = KIND_SINGLE0 + 6'd11;
      8'h3B:   r = KIND_SINGLE0 + 6'd12;
      default: r = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// File: src/stt_scan.sv
`timescale 1ns / 1ps
// Scanner state and next-state logic: turns one byte or end mark into up to three tokens.
// Depends on stt_pkg.
module stt_scan import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  ch_i,
  input  logic        end_of_input_i,
  output stt_pkt_t    pkt_o
);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_NUMBER_DOT, M_FRACTION, M_STRING, M_OPERATOR
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [COLUMN_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [KW_COUNT-1:0]    cand_q, cand_d;
  logic [7:0]             pend_q, pend_d;

  stt_res_t [MAX_RES-1:0] res_v;
  logic [1:0]             n_v;
  logic                   redisp_v;
  logic [5:0]             kind_v;

  function automatic stt_res_t mk(input logic [5:0] kind, input logic [LINE_BITS-1:0] l,
                                  input logic [COLUMN_BITS-1:0] col,
                                  input logic [LENGTH_BITS-1:0] n, input logic [7:0] sym);
    stt_res_t r;
    r.kind = kind;
    r.line = l;
    r.column = col;
    r.text_length = n;
    r.symbol_byte = sym;
    return r;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    start_d  = start_q;
    len_d    = len_q;
    cand_d   = cand_q;
    pend_d   = pend_q;
    res_v    = '0;
    n_v      = 2'd0;
    redisp_v = 1'b0;
    kind_v   = KIND_IDENT;

    // Identifier kind, needed by both the byte and the end paths.
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand_q[k] && LENGTH_BITS'(KW_LEN[k]) == len_q) kind_v = 6'(k + 1);
    end

    if (end_of_input_i) begin
      case (mode_q)
        M_IDENT: begin
          res_v[n_v] = mk(kind_v, line_q, start_q, len_q, 8'h00); n_v = n_v + 2'd1;
        end
        M_NUMBER, M_FRACTION, M_STRING: begin
          res_v[n_v] = mk((mode_q == M_STRING) ? KIND_STRING : KIND_NUMBER,
                          line_q, start_q, len_q, 8'h00);
          n_v = n_v + 2'd1;
        end
        M_NUMBER_DOT: begin
          res_v[n_v] = mk(KIND_NUMBER, line_q, start_q, len_q, 8'h00); n_v = n_v + 2'd1;
          res_v[n_v] = mk(KIND_UNKNOWN, line_q, col_d, LENGTH_BITS'(1), CH_DOT);
          n_v = n_v + 2'd1;
          col_d = col_adv(col_d, CH_DOT);
        end
        M_OPERATOR: begin
          case (pend_q)
            CH_EQ:   res_v[n_v] = mk(KIND_ASSIGN, line_q, start_q, LENGTH_BITS'(1), 8'h00);
            CH_LT:   res_v[n_v] = mk(KIND_LT, line_q, start_q, LENGTH_BITS'(1), 8'h00);
            CH_GT:   res_v[n_v] = mk(KIND_GT, line_q, start_q, LENGTH_BITS'(1), 8'h00);
            default: res_v[n_v] = mk(KIND_UNKNOWN, line_q, start_q, LENGTH_BITS'(1), pend_q);
          endcase
          n_v = n_v + 2'd1;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
      cand_d = KW_ALL;
      pend_d = 8'h00;
      res_v[n_v] = mk(KIND_END, line_q, col_d, '0, 8'h00);
      n_v = n_v + 2'd1;
    end else begin
      case (mode_q)
        M_IDENT: begin
          if (is_letter(ch_i) || is_digit(ch_i)) begin
            cand_d = kw_filter(cand_q, len_q, ch_i);
            len_d  = len_inc(len_q);
            line_d = line_adv(line_q, ch_i);
            col_d  = col_adv(col_q, ch_i);
          end else begin
            res_v[n_v] = mk(kind_v, line_q, start_q, len_q, 8'h00); n_v = n_v + 2'd1;
            redisp_v = 1'b1;
          end
        end
        M_NUMBER, M_FRACTION: begin
          if (is_digit(ch_i)) begin
            len_d = len_inc(len_q);
            col_d = col_adv(col_q, ch_i);
          end else if (ch_i == CH_DOT && mode_q == M_NUMBER) begin
            mode_d = M_NUMBER_DOT;
          end else begin
            res_v[n_v] = mk(KIND_NUMBER, line_q, start_q, len_q, 8'h00); n_v = n_v + 2'd1;
            redisp_v = 1'b1;
          end
        end
        M_NUMBER_DOT: begin
          if (is_digit(ch_i)) begin
            len_d  = len_inc(len_inc(len_q));
            col_d  = col_adv(col_adv(col_q, CH_DOT), ch_i);
            mode_d = M_FRACTION;
          end else begin
            res_v[n_v] = mk(KIND_NUMBER, line_q, start_q, len_q, 8'h00); n_v = n_v + 2'd1;
            res_v[n_v] = mk(KIND_UNKNOWN, line_q, col_q, LENGTH_BITS'(1), CH_DOT);
            n_v = n_v + 2'd1;
            col_d = col_adv(col_q, CH_DOT);
            redisp_v = 1'b1;
          end
        end
        M_STRING: begin
          line_d = line_adv(line_q, ch_i);
          col_d  = col_adv(col_q, ch_i);
          if (ch_i == CH_QUOTE) begin
            res_v[n_v] = mk(KIND_STRING, line_q, start_q, len_q, 8'h00); n_v = n_v + 2'd1;
            mode_d = M_IDLE;
            cand_d = KW_ALL;
            pend_d = 8'h00;
          end else begin
            len_d = len_inc(len_q);
          end
        end
        M_OPERATOR: begin
          if (ch_i == CH_EQ) begin
            col_d = col_adv(col_q, ch_i);
            case (pend_q)
              CH_EQ:   res_v[n_v] = mk(KIND_EQ, line_q, start_q, LENGTH_BITS'(2), 8'h00);
              CH_BANG: res_v[n_v] = mk(KIND_NE, line_q, start_q, LENGTH_BITS'(2), 8'h00);
              CH_LT:   res_v[n_v] = mk(KIND_LE, line_q, start_q, LENGTH_BITS'(2), 8'h00);
              default: res_v[n_v] = mk(KIND_GE, line_q, start_q, LENGTH_BITS'(2), 8'h00);
            endcase
            n_v = n_v + 2'd1;
            mode_d = M_IDLE;
            cand_d = KW_ALL;
            pend_d = 8'h00;
          end else begin
            case (pend_q)
              CH_EQ:   res_v[n_v] = mk(KIND_ASSIGN, line_q, start_q, LENGTH_BITS'(1), 8'h00);
              CH_LT:   res_v[n_v] = mk(KIND_LT, line_q, start_q, LENGTH_BITS'(1), 8'h00);
              CH_GT:   res_v[n_v] = mk(KIND_GT, line_q, start_q, LENGTH_BITS'(1), 8'h00);
              default: res_v[n_v] = mk(KIND_UNKNOWN, line_q, start_q, LENGTH_BITS'(1), pend_q);
            endcase
            n_v = n_v + 2'd1;
            redisp_v = 1'b1;
          end
        end
        default: redisp_v = 1'b1;
      endcase

      // Fresh scan of the byte from the idle state.
      if (redisp_v) begin
        mode_d = M_IDLE;
        cand_d = KW_ALL;
        pend_d = 8'h00;
        if (!is_space(ch_i)) begin
          start_d = col_d;
          if (is_letter(ch_i)) begin
            cand_d = kw_filter(KW_ALL, '0, ch_i);
            len_d  = LENGTH_BITS'(1);
            mode_d = M_IDENT;
          end else if (is_digit(ch_i)) begin
            len_d  = LENGTH_BITS'(1);
            mode_d = M_NUMBER;
          end else if (ch_i == CH_QUOTE) begin
            len_d  = '0;
            mode_d = M_STRING;
          end else if (ch_i == CH_EQ || ch_i == CH_BANG || ch_i == CH_LT || ch_i == CH_GT) begin
            pend_d = ch_i;
            mode_d = M_OPERATOR;
          end else begin
            res_v[n_v] = mk(single_kind(ch_i), line_q, col_d, LENGTH_BITS'(1),
                            (single_kind(ch_i) == KIND_UNKNOWN) ? ch_i : 8'h00);
            n_v = n_v + 2'd1;
          end
        end
        line_d = line_adv(line_d, ch_i);
        col_d  = col_adv(col_d, ch_i);
      end
    end
  end

  assign pkt_o.res   = res_v;
  assign pkt_o.count = n_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= LINE_BITS'(1);
      col_q   <= COLUMN_BITS'(1);
      start_q <= '0;
      len_q   <= '0;
      cand_q  <= KW_ALL;
      pend_q  <= 8'h00;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      start_q <= start_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// File: src/stt_emit.sv
`timescale 1ns / 1ps
// Result queue: holds the tokens of up to two input bytes and hands them out one per transfer.
// Depends on stt_pkg.
module stt_emit import stt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  stt_pkt_t pkt_i,
  output logic     can_load_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stt_res_t res_o,
  output logic     last_o
);

  stt_pkt_t   pkt_q;
  stt_pkt_t   spare_q;
  logic       valid_q;
  logic       spare_valid_q;
  logic [1:0] idx_q;
  logic       fin;

  assign last_o      = (idx_q == pkt_q.count - 2'd1);
  assign fin         = valid_q && out_ready_i && last_o;
  assign can_load_o  = !spare_valid_q;
  assign out_valid_o = valid_q;
  assign res_o       = pkt_q.res[idx_q];

  // The head packet is shown; a packet that arrives while the head waits goes to the spare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      spare_valid_q <= 1'b0;
      idx_q         <= 2'd0;
    end else if (fin) begin
      valid_q       <= spare_valid_q || load_i;
      spare_valid_q <= 1'b0;
      idx_q         <= 2'd0;
    end else if (!valid_q) begin
      valid_q <= load_i;
      idx_q   <= 2'd0;
    end else begin
      if (out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load_i) begin
        spare_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin && spare_valid_q) begin
      pkt_q <= spare_q;
    end else if (load_i && (!valid_q || fin)) begin
      pkt_q <= pkt_i;
    end
    if (load_i && valid_q && !fin) begin
      spare_q <= pkt_i;
    end
  end

endmodule

// File: src/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the source text tokenizer: byte scanner followed by a result queue.
// Depends on stt_pkg, stt_scan and stt_emit.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_ready_o | ch_i, end_of_input_i
//   out     | output    | out_valid_o/out_ready_i | kind, line, column, text_length, symbol
//                                                   byte, last
//
// Each accepted byte is scanned in the cycle of its transfer; its tokens (zero to three)
// are queued in a two-packet result queue, shown from the next cycle on if none wait ahead.
// One byte is taken every cycle while the queue has a free slot; with a token or less per
// byte and no back pressure the second slot is never taken, so bytes stream at full rate.
// Tokens leave one per cycle while out_ready_i is high, each packet's tokens in order.
// Reset returns the scanner to idle at line 1, column 1, with no token pending.
// A stall on the output holds the queue; the input is held off once both slots are taken.
module source_text_tokenizer import stt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             ch_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [5:0]             kind_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] column_o,
  output logic [LENGTH_BITS-1:0] text_length_o,
  output logic [7:0]             symbol_byte_o,
  output logic                   last_o
);

  stt_pkt_t pkt;
  stt_res_t res;
  logic     accept;

  // A byte transfers whenever one is offered and the spare slot of the result queue is free.
  assign accept = in_valid_i && in_ready_o;

  stt_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .pkt_o          (pkt)
  );

  // Bytes inside a token produce nothing, so only a nonempty packet is loaded.
  stt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && pkt.count != 2'd0),
    .pkt_i       (pkt),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign kind_o        = res.kind;
  assign line_o        = res.line;
  assign column_o      = res.column;
  assign text_length_o = res.text_length;
  assign symbol_byte_o = res.symbol_byte;

endmodule

// File: src/stt_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the source text tokenizer, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer.
module stt_checker import stt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [5:0]             kind_o,
  input logic [LINE_BITS-1:0]   line_o,
  input logic [COLUMN_BITS-1:0] column_o,
  input logic [7:0]             symbol_byte_o,
  input logic                   last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o))
    else $error("output token dropped or changed while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_END |-> last_o)
    else $error("end token is not the final token of its byte");

  a_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_byte_o != 8'h00 |-> kind_o == KIND_UNKNOWN)
    else $error("symbol byte set on a known token");

  a_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_o != '0 && column_o != '0 && kind_o <= KIND_END)
    else $error("token with bad position or kind");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .line_o        (line_o),
  .column_o      (column_o),
  .symbol_byte_o (symbol_byte_o),
  .last_o        (last_o)
);
